FILE: src/tdq_pkg.sv
`timescale 1ns / 1ps
package tdq_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int DENS_W    = 11;
  localparam int DZ_W      = 7;
  localparam int DIR_W     = 4;
  localparam int THP_W     = 16;   // 18 * max density fits in 16 bits

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_MODE = 3'd6;

  // Direction bits
  localparam logic [DIR_W-1:0] DIR_NONE  = 4'b0000;
  localparam logic [DIR_W-1:0] DIR_UP    = 4'b0001;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 4'b0010;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 4'b0100;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 4'b1000;

  // Reset values
  localparam int             PAD_EDGE_RST = 2304;
  localparam logic [DENS_W-1:0] DENS_RST  = 11'd256;
  localparam logic [DZ_W-1:0]   DZ_RST    = 7'd56;

  // Held dead zone: max(20, dz - 15)
  localparam logic [DZ_W-1:0] DZ_DROP     = 7'd15;
  localparam logic [DZ_W-1:0] DZ_FLOOR    = 7'd20;
  localparam logic [DZ_W-1:0] DZ_DROP_MIN = 7'd35;

  // Pad thresholds in units of density
  localparam logic [THP_W-1:0] TH_FREE = 16'd18;
  localparam logic [THP_W-1:0] TH_HELD = 16'd12;

  typedef enum logic [1:0] {
    MUL_SQX  = 2'd0,
    MUL_SQY  = 2'd1,
    MUL_LIM  = 2'd2,
    MUL_LIM2 = 2'd3
  } mul_op_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQX  = 7'b0000010,
    S_SQY  = 7'b0000100,
    S_LIM  = 7'b0001000,
    S_LIM2 = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_DEC  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    mul_en;
    mul_op_t mul_op;
    logic    sum_en;
    logic    dec_en;
  } dp_cmd_t;

  typedef struct packed {
    logic stick;
  } dp_sts_t;

endpackage

FILE: src/tdq_ctrl.sv
`timescale 1ns / 1ps
module tdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tdq_pkg::dp_sts_t  sts,
  output tdq_pkg::dp_cmd_t  cmd
);
  import tdq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.mul_en  = 1'b0;
    cmd.mul_op  = MUL_SQX;
    cmd.sum_en  = 1'b0;
    cmd.dec_en  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.stick ? S_SQX : S_DEC;
        end
      end
      S_SQX: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SQX;
        state_nxt  = S_SQY;
      end
      S_SQY: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SQY;
        state_nxt  = S_LIM;
      end
      S_LIM: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_LIM;
        state_nxt  = S_LIM2;
      end
      S_LIM2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_LIM2;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_DEC;
      end
      S_DEC: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.dec_en = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.dec_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/tdq_dp.sv
`timescale 1ns / 1ps
module tdq_dp #(
  parameter int COORD_BITS = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tdq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]          cfg_data,
  input  logic [COORD_BITS-1:0]          in_touch_x,
  input  logic [COORD_BITS-1:0]          in_touch_y,
  input  logic                           in_new_touch,
  input  tdq_pkg::dp_cmd_t               cmd,
  output tdq_pkg::dp_sts_t               sts,
  output logic [tdq_pkg::DIR_W-1:0]      out_direction
);
  import tdq_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int OW  = CW + 7;        // multiplier operand
  localparam int PW  = 2 * OW;        // multiplier product
  localparam int QW  = 2 * CW + 2;    // one squared offset
  localparam int SW  = QW + 1;        // sum of squares
  localparam int LW  = PW - 15;       // rounded squared limit
  localparam int PDW = CW + 5;        // pad containment compare
  localparam int AXW = CW + 6;        // 20*ax, 11*ay
  localparam int P8W = CW + 4;        // 8*ax vs pad threshold

  // configuration
  logic [CW-1:0]     pad_left_r, pad_top_r, pad_right_r, pad_bottom_r;
  logic [DENS_W-1:0] dens_r;
  logic [DZ_W-1:0]   dz_r;
  logic              stick_r;
  logic [DIR_W-1:0]  held_dir_r;
  logic [DIR_W-1:0]  out_dir_r;

  // captured item
  logic [CW-1:0]     x_r, y_r;
  logic              held_r;
  logic              dxneg_r, dyneg_r, mneg_r;
  logic [CW:0]       ax_r, ay_r;
  logic [DZ_W-1:0]   th_r;
  logic [CW-1:0]     m_r;

  // stick arithmetic
  logic [QW-1:0]     sqx_r, sqy_r;
  logic [OW-1:0]     lim1_r;
  logic [PW-1:0]     lim2_r;
  logic [SW-1:0]     s_r;
  logic [LW-1:0]     limc_r;

  // capture logic
  logic [CW+1:0]     lr_sum, tb_sum, dx2, dy2;
  logic [CW:0]       ax_c, ay_c;
  logic [CW:0]       w_c, h_c;
  logic              mneg_c;
  logic [CW-1:0]     m_c;
  logic              held_c;
  logic [DZ_W-1:0]   th_c;

  // multiplier
  logic [OW-1:0]     mul_a, mul_b;
  logic [PW-1:0]     prod;
  logic [PW:0]       lim_add;

  // decision
  logic [PDW-1:0]    x16, y16, l16, t16, r16, b16, rel;
  logic              outside;
  logic [THP_W-1:0]  thp;
  logic [P8W-1:0]    ax8, ay8, thp_ext;
  logic              gex, gey, leftp, rightp, upp, downp;
  logic [DIR_W-1:0]  pad_dir, stick_dir, dir_c;
  logic [AXW-1:0]    ax20, ax11, ay20, ay11;
  logic              pass;

  assign sts.stick     = stick_r;
  assign out_direction = out_dir_r;

  always_comb begin
    lr_sum = {2'b00, pad_left_r} + {2'b00, pad_right_r};
    tb_sum = {2'b00, pad_top_r} + {2'b00, pad_bottom_r};
    dx2    = {1'b0, in_touch_x, 1'b0} - lr_sum;
    dy2    = {1'b0, in_touch_y, 1'b0} - tb_sum;
    ax_c   = dx2[CW+1] ? (~dx2[CW:0] + 1'b1) : dx2[CW:0];
    ay_c   = dy2[CW+1] ? (~dy2[CW:0] + 1'b1) : dy2[CW:0];
    w_c    = {1'b0, pad_right_r} - {1'b0, pad_left_r};
    h_c    = {1'b0, pad_bottom_r} - {1'b0, pad_top_r};
    mneg_c = w_c[CW] | h_c[CW];
    m_c    = ($signed(w_c) < $signed(h_c)) ? w_c[CW-1:0] : h_c[CW-1:0];
    held_c = !in_new_touch && (held_dir_r != DIR_NONE);
    if (!held_c) begin
      th_c = dz_r;
    end else if (dz_r >= DZ_DROP_MIN) begin
      th_c = dz_r - DZ_DROP;
    end else begin
      th_c = DZ_FLOOR;
    end
  end

  always_comb begin
    case (cmd.mul_op)
      MUL_SQX: begin
        mul_a = OW'(ax_r);
        mul_b = OW'(ax_r);
      end
      MUL_SQY: begin
        mul_a = OW'(ay_r);
        mul_b = OW'(ay_r);
      end
      MUL_LIM: begin
        mul_a = OW'(th_r);
        mul_b = OW'(m_r);
      end
      MUL_LIM2: begin
        mul_a = lim1_r;
        mul_b = lim1_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod    = PW'(mul_a) * PW'(mul_b);
    lim_add = {1'b0, lim2_r} + (PW+1)'(65535);
  end

  always_comb begin
    // pad mode: box test, widened while held
    x16 = PDW'({x_r, 4'b0000});
    y16 = PDW'({y_r, 4'b0000});
    l16 = PDW'({pad_left_r, 4'b0000});
    t16 = PDW'({pad_top_r, 4'b0000});
    r16 = PDW'({pad_right_r, 4'b0000});
    b16 = PDW'({pad_bottom_r, 4'b0000});
    rel = held_r ? PDW'({dens_r, 3'b000}) : '0;
    outside = (x16 + rel < l16) || (x16 > r16 + rel) ||
              (y16 + rel < t16) || (y16 > b16 + rel);
    thp     = held_r ? ({5'b00000, dens_r} * TH_HELD) : ({5'b00000, dens_r} * TH_FREE);
    thp_ext = P8W'(thp);
    ax8     = {ax_r, 3'b000};
    ay8     = {ay_r, 3'b000};
    gex     = ax8 >= thp_ext;
    gey     = ay8 >= thp_ext;
    // a zero offset counts as negative when the threshold is zero
    leftp   = (dxneg_r || (ax_r == '0)) && gex;
    rightp  = !leftp && !dxneg_r && gex;
    upp     = (dyneg_r || (ay_r == '0)) && gey;
    downp   = !upp && !dyneg_r && gey;
    pad_dir = DIR_NONE;
    if (!outside) begin
      if (leftp)  pad_dir = pad_dir | DIR_LEFT;
      if (rightp) pad_dir = pad_dir | DIR_RIGHT;
      if (upp)    pad_dir = pad_dir | DIR_UP;
      if (downp)  pad_dir = pad_dir | DIR_DOWN;
    end

    // stick mode: squared dead zone and axis ratio
    ax20 = AXW'(ax_r) * AXW'(20);
    ax11 = AXW'(ax_r) * AXW'(11);
    ay20 = AXW'(ay_r) * AXW'(20);
    ay11 = AXW'(ay_r) * AXW'(11);
    pass = !(s_r < SW'(limc_r));
    stick_dir = DIR_NONE;
    if (!mneg_r && pass) begin
      if (ax20 >= ay11) stick_dir = stick_dir | (dxneg_r ? DIR_LEFT : DIR_RIGHT);
      if (ay20 >= ax11) stick_dir = stick_dir | (dyneg_r ? DIR_UP : DIR_DOWN);
    end

    dir_c = stick_r ? stick_dir : pad_dir;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_left_r   <= '0;
      pad_top_r    <= '0;
      pad_right_r  <= CW'(PAD_EDGE_RST);
      pad_bottom_r <= CW'(PAD_EDGE_RST);
      dens_r       <= DENS_RST;
      dz_r         <= DZ_RST;
      stick_r      <= 1'b0;
      held_dir_r   <= DIR_NONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PAD_LEFT:   pad_left_r   <= cfg_data;
          REG_PAD_TOP:    pad_top_r    <= cfg_data;
          REG_PAD_RIGHT:  pad_right_r  <= cfg_data;
          REG_PAD_BOTTOM: pad_bottom_r <= cfg_data;
          REG_DENSITY:    dens_r       <= cfg_data[DENS_W-1:0];
          REG_DEAD_ZONE:  dz_r         <= cfg_data[DZ_W-1:0];
          REG_STICK_MODE: stick_r      <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.dec_en) begin
        held_dir_r <= dir_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r     <= in_touch_x;
      y_r     <= in_touch_y;
      held_r  <= held_c;
      dxneg_r <= dx2[CW+1];
      dyneg_r <= dy2[CW+1];
      ax_r    <= ax_c;
      ay_r    <= ay_c;
      mneg_r  <= mneg_c;
      m_r     <= m_c;
      th_r    <= th_c;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_op)
        MUL_SQX:  sqx_r  <= prod[QW-1:0];
        MUL_SQY:  sqy_r  <= prod[QW-1:0];
        MUL_LIM:  lim1_r <= prod[OW-1:0];
        MUL_LIM2: lim2_r <= prod;
        default: ;
      endcase
    end
    if (cmd.sum_en) begin
      s_r    <= SW'(sqx_r) + SW'(sqy_r);
      limc_r <= lim_add[PW:16];
    end
    if (cmd.dec_en) begin
      out_dir_r <= dir_c;
    end
  end

endmodule

FILE: src/touch_direction_quantizer.sv
`timescale 1ns / 1ps
// Sequence: capture, then the decision in pad mode; stick mode puts sqx, sqy,
//   lim, lim2 and sum between them; the decision waits on a stalled result.
// One sample at a time, the next after the last is decided; the stick path
//   runs four products through a single shared multiplier.
// Reset (rst_n low, synchronous): registers return to their reset values,
//   no direction is held, no result is pending.
module touch_direction_quantizer #(
  parameter int COORD_BITS = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // touch samples
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [COORD_BITS-1:0]          in_touch_x,
  input  logic [COORD_BITS-1:0]          in_touch_y,
  input  logic                           in_new_touch,
  // direction results
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tdq_pkg::DIR_W-1:0]      out_direction,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tdq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]          cfg_data
);
  import tdq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  // Register writes are always accepted, so the write channel never stalls.
  // Indexes past the register list are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // The controller sequences one item at a time:
  //   idle      take a beat and capture offsets, radius and dead zone
  //   sqx..lim2 drive the shared multiplier, one product per cycle
  //   sum       add the squares and round the squared limit
  //   dec       form the direction, load the result register and held state
  // Pad mode skips straight from capture to decision. The result register
  // holds a finished beat while the next item is captured and worked on.
  tdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath keeps the configuration, the held direction used for
  // hysteresis, the captured item and the result register.
  tdq_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_touch_x    (in_touch_x),
    .in_touch_y    (in_touch_y),
    .in_new_touch  (in_new_touch),
    .cmd           (cmd),
    .sts           (sts),
    .out_direction (out_direction)
  );

endmodule

FILE: src/tdq_checker.sv
`timescale 1ns / 1ps
module tdq_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [tdq_pkg::DIR_W-1:0]      out_direction
);
  import tdq_pkg::*;

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_direction))
    else $error("result beat changed while stalled");

  // One item in flight: intake closes right after a beat is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  // A new result only appears after the intake was closed for the work.
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work cycle");

  // Opposite directions never fire together.
  a_no_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((out_direction & (DIR_UP | DIR_DOWN)) == (DIR_UP | DIR_DOWN)) &&
                  !((out_direction & (DIR_LEFT | DIR_RIGHT)) == (DIR_LEFT | DIR_RIGHT)))
    else $error("opposite directions in one result");

endmodule

bind touch_direction_quantizer tdq_checker u_tdq_checker (.*);

FILE: test/tdq_checker.sv
`timescale 1ns / 1ps
module tdq_scoreboard #(
  parameter int COORD_BITS = 17
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [COORD_BITS-1:0]         in_touch_x,
  input  logic [COORD_BITS-1:0]         in_touch_y,
  input  logic                          in_new_touch,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [tdq_pkg::DIR_W-1:0]     out_direction,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tdq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]         cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import tdq_pkg::*;

  localparam int MAX_REPORTS = 10;

  // shadow copy of the register file and the hysteresis state
  logic [COORD_BITS-1:0] box_left, box_top, box_right, box_bottom;
  logic [DENS_W-1:0]     density;
  logic [DZ_W-1:0]       dead_zone_q;
  logic                  stick;
  logic [DIR_W-1:0]      held_dir;

  logic [DIR_W-1:0]      pending_dirs[$];

  function automatic logic [DIR_W-1:0] pad_direction(longint x, longint y, bit held);
    longint l, t, r, b, d, rel, th, dx8, dy8;
    logic [DIR_W-1:0] bits;
    l = box_left;
    t = box_top;
    r = box_right;
    b = box_bottom;
    d = density;
    rel = held ? 8 * d : 0;
    th = (held ? 12 : 18) * d;
    bits = DIR_NONE;
    if (16 * x < 16 * l - rel || 16 * x > 16 * r + rel ||
        16 * y < 16 * t - rel || 16 * y > 16 * b + rel)
      return DIR_NONE;
    dx8 = 8 * (2 * x - (l + r));
    dy8 = 8 * (2 * y - (t + b));
    if (dx8 <= -th) bits |= DIR_LEFT;
    else if (dx8 >= th) bits |= DIR_RIGHT;
    if (dy8 <= -th) bits |= DIR_UP;
    else if (dy8 >= th) bits |= DIR_DOWN;
    return bits;
  endfunction

  function automatic logic [DIR_W-1:0] stick_direction(longint x, longint y, bit held);
    longint l, t, r, b, w, h, m, dx2, dy2, ax, ay, th, lim, s;
    logic [DIR_W-1:0] bits;
    l = box_left;
    t = box_top;
    r = box_right;
    b = box_bottom;
    w = r - l;
    h = b - t;
    m = (w < h) ? w : h;
    dx2 = 2 * x - (l + r);
    dy2 = 2 * y - (t + b);
    bits = DIR_NONE;
    if (m < 0)
      return DIR_NONE;
    // held dead zone drops by 15/256, floored at 20/256
    th = dead_zone_q;
    if (held)
      th = (th >= 35) ? th - 15 : 20;
    ax = (dx2 < 0) ? -dx2 : dx2;
    ay = (dy2 < 0) ? -dy2 : dy2;
    s = ax * ax + ay * ay;
    lim = th * m;
    lim = (lim * lim + 65535) >> 16;
    if (s < lim)
      return DIR_NONE;
    if (20 * ax >= 11 * ay) bits |= (dx2 < 0) ? DIR_LEFT : DIR_RIGHT;
    if (20 * ay >= 11 * ax) bits |= (dy2 < 0) ? DIR_UP : DIR_DOWN;
    return bits;
  endfunction

  function automatic logic [DIR_W-1:0] next_direction(logic [COORD_BITS-1:0] x,
                                                      logic [COORD_BITS-1:0] y,
                                                      logic new_touch);
    bit held;
    logic [DIR_W-1:0] dir;
    held = !new_touch && (held_dir != DIR_NONE);
    dir = stick ? stick_direction(x, y, held) : pad_direction(x, y, held);
    held_dir = dir;
    return dir;
  endfunction

  task automatic flag(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s", msg);
  endtask

  always @(posedge clk) begin : watch
    logic [DIR_W-1:0] due;
    if (!rst_n) begin
      box_left    = '0;
      box_top     = '0;
      box_right   = COORD_BITS'(PAD_EDGE_RST);
      box_bottom  = COORD_BITS'(PAD_EDGE_RST);
      density     = DENS_RST;
      dead_zone_q = DZ_RST;
      stick       = 1'b0;
      held_dir    = DIR_NONE;
      pending_dirs.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_dirs.size() == 0) begin
          flag($sformatf("[%0t] unexpected direction beat %b", $realtime, out_direction));
        end else begin
          due = pending_dirs.pop_front();
          if (out_direction !== due)
            flag($sformatf("[%0t] direction mismatch: expected %b, got %b",
                           $realtime, due, out_direction));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PAD_LEFT:   box_left    = cfg_data;
          REG_PAD_TOP:    box_top     = cfg_data;
          REG_PAD_RIGHT:  box_right   = cfg_data;
          REG_PAD_BOTTOM: box_bottom  = cfg_data;
          REG_DENSITY:    density     = cfg_data[DENS_W-1:0];
          REG_DEAD_ZONE:  dead_zone_q = cfg_data[DZ_W-1:0];
          REG_STICK_MODE: stick       = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_dirs.insert(pending_dirs.size(),
                            next_direction(in_touch_x, in_touch_y, in_new_touch));
    end
    pending = pending_dirs.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tdq_pkg::*;

  localparam int COORD_BITS      = 17;
  localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
  localparam int HOLD_OFF_CYCLES = 200;  // long receiver stall to back the block up
  localparam int TAIL_CYCLES     = 20;   // well past the stick-mode latency
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 55;

  // index past the last register; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COORD_BITS-1:0] in_touch_x = '0;
  logic [COORD_BITS-1:0] in_touch_y = '0;
  logic                  in_new_touch = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DIR_W-1:0]      out_direction;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COORD_BITS-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit calm = 1'b0;          // no idling on either side while set
  bit hold_off_req = 1'b0;  // ask the result sink for one long stall

  always #1 clk = ~clk;

  touch_direction_quantizer #(.COORD_BITS(COORD_BITS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_touch_x(in_touch_x), .in_touch_y(in_touch_y), .in_new_touch(in_new_touch),
    .out_valid(out_valid), .out_ready(out_ready), .out_direction(out_direction),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tdq_scoreboard #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_touch_x(in_touch_x), .in_touch_y(in_touch_y), .in_new_touch(in_new_touch),
    .out_valid(out_valid), .out_ready(out_ready), .out_direction(out_direction),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Pick a coordinate inside the span [lo, hi] or a little outside it.
  function automatic int near(int lo, int hi);
    int a, z, margin;
    a = (lo < hi) ? lo : hi;
    z = (lo < hi) ? hi : lo;
    margin = (z - a) / 4 + 64;
    return clamp(a - margin + int'($urandom_range(0, z - a + 2 * margin)));
  endfunction

  // Result sink: random ready stretches, none while calm, and one long
  // hold-off on request, counted here so the sender keeps offering beats.
  initial begin : result_sink
    int stretch;
    int g;
    stretch = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (stretch > 0) begin
        stretch--;
      end else if (out_ready) begin
        g = idle_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          stretch = g - 1;
        end else begin
          stretch = $urandom_range(0, 15);
        end
      end else begin
        out_ready <= 1'b1;
        stretch = $urandom_range(0, 15);
      end
    end
  end

  // Write one register; enter anywhere, leave at a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[COORD_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offer one touch beat; enter and leave at a falling edge. Keep valid
  // high across back-to-back beats, drop it only for an idle gap.
  task automatic send_touch(input int x, input int y, input bit nt);
    int gap;
    in_valid     <= 1'b1;
    in_touch_x   <= x[COORD_BITS-1:0];
    in_touch_y   <= y[COORD_BITS-1:0];
    in_new_touch <= nt;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid, wait for every predicted direction to come back, then
  // let TAIL_CYCLES pass before anything else happens.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // Gestures around the box: press then drag, with some drags that start
  // without a press or re-press midway, plus full-range noise.
  task automatic run_touches(input int count, input int l, input int t,
                             input int r, input int b);
    int done, steps, jump, x, y, k;
    done = 0;
    jump = ((r > l ? r - l : l - r) + (b > t ? b - t : t - b)) / 16 + 8;
    while (done < count) begin
      if ($urandom_range(0, 9) < 2) begin
        send_touch($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   1'($urandom_range(0, 1)));
        done++;
      end else begin
        steps = $urandom_range(2, 8);
        x = near(l, r);
        y = near(t, b);
        send_touch(x, y, $urandom_range(0, 4) != 0);
        done++;
        for (k = 0; k < steps && done < count; k++) begin
          x = clamp(x + int'($urandom_range(0, 2 * jump)) - jump);
          y = clamp(y + int'($urandom_range(0, 2 * jump)) - jump);
          send_touch(x, y, $urandom_range(0, 19) == 0);
          done++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int ph, l, t, r, b, dens, dz, stk, w, h;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, pad box 0..2304, density 1.0.
    write_reg(REG_UNUSED, COORD_MAX);
    send_touch(1152, 1152, 1'b1);           // centre: nothing
    send_touch(0, 0, 1'b1);                 // corner: up and left
    send_touch(2304, 2304, 1'b0);           // opposite corner, held
    send_touch(2400, 1152, 1'b0);           // outside, but inside the held margin
    send_touch(2400, 1152, 1'b1);           // same spot as a new touch: nothing
    send_touch(COORD_MAX, COORD_MAX, 1'b0); // far corner of the field
    send_touch(1100, 1152, 1'b1);
    send_touch(864, 1152, 1'b0);            // exactly on the free threshold
    send_touch(1000, 1152, 1'b0);           // within the held threshold
    settle();

    // Zero density through a masked write: centre counts as up and left.
    write_reg(REG_DENSITY, 12'h800);
    send_touch(1152, 1152, 1'b1);
    send_touch(1152, 1152, 1'b0);
    settle();

    // Inverted box in pad mode contains nothing.
    write_reg(REG_PAD_LEFT, 3000);
    send_touch(2500, 1152, 1'b1);
    settle();

    // Stick mode, zero-width box, dead zone below the floor.
    write_reg(REG_STICK_MODE, 1);
    write_reg(REG_DEAD_ZONE, 5);
    write_reg(REG_PAD_LEFT, 1152);
    write_reg(REG_PAD_RIGHT, 1152);
    send_touch(1152, 1152, 1'b1);           // zero radius: centre gives right and down
    send_touch(1153, 1152, 1'b0);
    settle();

    write_reg(REG_PAD_LEFT, 0);
    write_reg(REG_PAD_RIGHT, PAD_EDGE_RST);
    send_touch(1152, 1152, 1'b1);           // exact centre inside the dead zone
    send_touch(1300, 1152, 1'b1);
    send_touch(1152, 900, 1'b0);
    send_touch(1300, 1300, 1'b0);
    send_touch(0, 0, 1'b0);
    settle();

    // Inverted box in stick mode: negative radius, never a direction.
    write_reg(REG_PAD_TOP, 3000);
    send_touch(1152, 1152, 1'b1);
    send_touch(0, COORD_MAX, 1'b0);
    settle();

    // Random phases, each with its own register settings.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = (ph == 3) || (ph == 4);
      case (ph)
        0: begin  // all-ones data: widest box, densest, largest dead zone
          l = 0; t = 0; r = COORD_MAX; b = COORD_MAX;
          dens = COORD_MAX; dz = COORD_MAX; stk = COORD_MAX;
        end
        1: begin  // all zeros
          l = 0; t = 0; r = 0; b = 0; dens = 0; dz = 0; stk = 0;
        end
        2: begin  // low ends of the sensible range
          l = 40000; t = 40000; r = 41000; b = 40600; dens = 64; dz = 20; stk = 1;
        end
        3: begin  // high ends of the sensible range
          l = 1000; t = 2000; r = 9000; b = 6000; dens = 1024; dz = 115; stk = 0;
        end
        default: begin
          l = $urandom_range(0, COORD_MAX);
          t = $urandom_range(0, COORD_MAX);
          w = ($urandom_range(0, 9) == 0) ? -int'($urandom_range(0, 500))
                                          : int'($urandom_range(0, 6000));
          h = ($urandom_range(0, 9) == 0) ? -int'($urandom_range(0, 500))
                                          : int'($urandom_range(0, 6000));
          r = clamp(l + w);
          b = clamp(t + h);
          dens = ($urandom_range(0, 4) == 0) ? $urandom_range(0, COORD_MAX)
                                             : $urandom_range(64, 1024);
          dz = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                           : $urandom_range(20, 115);
          stk = ph % 2;
        end
      endcase
      write_reg(REG_PAD_LEFT, l);
      write_reg(REG_PAD_TOP, t);
      write_reg(REG_PAD_RIGHT, r);
      write_reg(REG_PAD_BOTTOM, b);
      write_reg(REG_DENSITY, dens);
      write_reg(REG_DEAD_ZONE, dz);
      write_reg(REG_STICK_MODE, stk);
      // stall the result side while beats keep coming back to back
      if (ph == 4)
        hold_off_req = 1'b1;
      run_touches(ITEMS_PER_PHASE, l, t, r, b);
      settle();
    end

    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
src/tdq_pkg.sv
src/tdq_ctrl.sv
src/tdq_dp.sv
src/touch_direction_quantizer.sv
src/tdq_checker.sv
test/tdq_checker.sv
test/tb_top.sv
